### rtl/core/sset_pkg.sv
package sset_pkg;

  localparam int CAPACITY_DEFAULT = 64;
  localparam int VALUE_W          = 32;
  localparam int COUNT_OUT_W      = 7;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_RSVD   = 2'd3
  } action_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

### rtl/core/sset_if.sv
interface sset_req_if import sset_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface sset_rsp_if import sset_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   was_present;
  logic                   full_reject;
  logic [COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, was_present, full_reject, entry_count, input ready);
  modport sink   (input valid, was_present, full_reject, entry_count, output ready);
endinterface

### rtl/core/sset_cell.sv
module sset_cell import sset_pkg::*; (
  input  logic                      clk,
  input  cell_ctrl_t                ctrl,
  input  logic                      held,
  input  logic                      take_key,
  input  logic signed [VALUE_W-1:0] key,
  input  logic signed [VALUE_W-1:0] left_value,
  input  logic signed [VALUE_W-1:0] right_value,
  output logic signed [VALUE_W-1:0] value,
  output logic                      lt,
  output logic                      eq
);

  logic signed [VALUE_W-1:0] value_next;

  assign lt = held && (value < key);
  assign eq = held && (value == key);

  always_comb begin
    value_next = value;
    if (ctrl.ins && !lt) begin
      value_next = take_key ? key : left_value;
    end else if (ctrl.rem && !lt) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

### rtl/core/sorted_set_insert_remove_query.sv
// Sorted set of distinct signed 32-bit values, up to CAPACITY entries.
// req channel (sink): action (add, remove, query; code 3 acts as query) and
// value. rsp channel (source): was_present, full_reject and entry_count
// (low 7 bits of the number held after the request).
// Storage is a row of cells kept in ascending order. Every cell compares the
// broadcast value in the cycle a beat is accepted; on add the cells at and
// above the insert point shift up by one, on remove they shift down by one.
// The response is registered and shows in the cycle after acceptance.
// One request per cycle while the receiver keeps up, as the compare and
// shift across the cell row complete in the cycle a beat is accepted.
// req.ready = !rsp.valid || rsp.ready, so a waiting response that is taken
// in the same cycle does not stop the next beat; while the receiver stalls,
// the response holds and no new request is taken.
// Reset (rst, synchronous) empties the set and drops any pending response;
// cell contents are not cleared, only the entry count.
module sorted_set_insert_remove_query import sset_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  sset_req_if.sink   req,
  sset_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic                      fire;
  logic                      present;
  logic                      full;
  logic                      reject;
  cell_ctrl_t                ctrl;
  logic [CAPACITY-1:0]       lt;
  logic [CAPACITY-1:0]       eq;
  logic signed [VALUE_W-1:0] cell_value [CAPACITY];
  logic [CW+COUNT_OUT_W-1:0] count_ext;

  assign req.ready = !rsp.valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign present   = |eq;
  assign full      = (count == CW'(CAPACITY));

  always_comb begin
    ctrl   = '0;
    reject = 1'b0;
    unique case (action_t'(req.action))
      ACT_ADD: begin
        ctrl.ins = fire && !present && !full;
        reject   = !present && full;
      end
      ACT_REMOVE: begin
        ctrl.rem = fire && present;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CW'(1);
    end else if (ctrl.rem) begin
      count_next = count - CW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      held;
    logic                      take_key;
    logic signed [VALUE_W-1:0] left_value;
    logic signed [VALUE_W-1:0] right_value;

    assign held = (CW'(i) < count);

    if (i == 0) begin : g_head
      assign take_key   = 1'b1;
      assign left_value = req.value;
    end else begin : g_body
      assign take_key   = lt[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    sset_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .held        (held),
      .take_key    (take_key),
      .key         (req.value),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_value[i]),
      .lt          (lt[i]),
      .eq          (eq[i])
    );
  end

  assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.was_present <= present;
      rsp.full_reject <= reject;
      rsp.entry_count <= count_ext[COUNT_OUT_W-1:0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(eq))
    else $error("value matched in more than one cell");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> count == $past(count) + CW'(1))
    else $error("add did not grow the set by one");

  a_reject_absent: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.full_reject |-> !rsp.was_present)
    else $error("reject flagged for a value already held");

endmodule

### sim/sset_reply_check.sv
`timescale 1ns / 1ps
module sset_reply_check import sset_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  sset_req_if  req,
  sset_rsp_if  rsp,
  output int   mismatches,
  output int   pending,
  output int   replies,
  output int   hits,
  output int   rejects,
  output int   peak_fill
);

  typedef struct packed {
    logic                   was_present;
    logic                   full_reject;
    logic [COUNT_OUT_W-1:0] entry_count;
  } reply_t;

  // shadow of the set, ascending signed order
  logic signed [VALUE_W-1:0] held_vals[$];
  reply_t                    want_q[$];

  function automatic reply_t apply_request(action_t act, logic signed [VALUE_W-1:0] v);
    reply_t r;
    int     pos;
    bit     hit;
    pos = 0;
    while (pos < held_vals.size() && held_vals[pos] < v) pos++;
    hit = (pos < held_vals.size()) && (held_vals[pos] == v);
    r.was_present = hit;
    r.full_reject = 1'b0;
    case (act)
      ACT_ADD: begin
        if (!hit) begin
          if (held_vals.size() >= CAPACITY) r.full_reject = 1'b1;
          else held_vals.insert(pos, v);
        end
      end
      ACT_REMOVE: begin
        if (hit) held_vals.delete(pos);
      end
      default: ;
    endcase
    r.entry_count = COUNT_OUT_W'(held_vals.size());
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      held_vals.delete();
      want_q.delete();
      mismatches = 0;
      replies    = 0;
      hits       = 0;
      rejects    = 0;
      peak_fill  = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        replies++;
        if (want_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: reply beat with nothing outstanding: present=%b reject=%b count=%0d",
                     $time, rsp.was_present, rsp.full_reject, rsp.entry_count);
        end else begin
          want = want_q.pop_front();
          if (rsp.was_present !== want.was_present || rsp.full_reject !== want.full_reject ||
              rsp.entry_count !== want.entry_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: reply mismatch: exp present=%b reject=%b count=%0d, got %b %b %0d",
                       $time, want.was_present, want.full_reject, want.entry_count,
                       rsp.was_present, rsp.full_reject, rsp.entry_count);
          end
        end
      end
      if (req.valid && req.ready) begin
        want = apply_request(action_t'(req.action), req.value);
        want_q.push_back(want);
        hits    += want.was_present;
        rejects += want.full_reject;
        if (held_vals.size() > peak_fill) peak_fill = held_vals.size();
      end
    end
    pending = want_q.size();
  end

endmodule

### sim/tb_sorted_set_insert_remove_query.sv
`timescale 1ns / 1ps
module tb_sorted_set_insert_remove_query;
  import sset_pkg::*;

  localparam int LIMIT    = 200000;
  localparam int POOL_N   = 96;
  localparam int HOLD_OFF = 400;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches, pending, replies, hits, rejects, peak_fill;
  int   items_sent = 0;
  int   burst_left = 0;
  int   cycle_cnt  = 0;
  logic signed [VALUE_W-1:0] pool[POOL_N];

  sset_req_if req_ch();
  sset_rsp_if rsp_ch();

  sorted_set_insert_remove_query uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sset_reply_check chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .replies    (replies),
    .hits       (hits),
    .rejects    (rejects),
    .peak_fill  (peak_fill)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // holds valid across a burst; drops it only for a gap
  task automatic offer(input action_t act, input logic signed [VALUE_W-1:0] v);
    int gap;
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.value  <= v;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
    end
  endtask

  // reply side: stall pattern plus one long hold-off to back up the request side
  initial begin
    int mode, len, phase;
    bit held_off;
    held_off = 1'b0;
    phase    = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held_off && items_sent >= 300) begin
        held_off = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(4, 60);
      repeat (len) begin
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
          2:       rsp_ch.ready <= ($urandom_range(0, 9) < 3);
          default: rsp_ch.ready <= (phase % 3 != 0);
        endcase
        phase++;
        @(posedge clk);
      end
    end
  end

  initial begin
    int seg, add_pct, rem_pct, r;
    action_t act;
    logic signed [VALUE_W-1:0] v;
    logic signed [VALUE_W-1:0] base;
    req_ch.valid  <= 1'b0;
    req_ch.action <= ACT_QUERY;
    req_ch.value  <= '0;
    pool[0] = VAL_MIN;
    pool[1] = VAL_MAX;
    pool[2] = 0;
    pool[3] = -1;
    pool[4] = 1;
    pool[5] = VAL_MIN + 1;
    base = $urandom;
    // a run of neighbors checks ordering of adjacent values
    for (int i = 6; i < POOL_N; i++) pool[i] = (i < 22) ? base + i : $urandom;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 20);

    offer(ACT_QUERY,  VAL_MIN);
    offer(ACT_REMOVE, VAL_MIN);
    offer(ACT_ADD,    VAL_MIN);
    offer(ACT_ADD,    VAL_MAX);
    offer(ACT_ADD,    0);
    offer(ACT_ADD,    -1);
    offer(ACT_ADD,    1);
    offer(ACT_ADD,    VAL_MAX);
    offer(ACT_QUERY,  VAL_MAX);
    offer(ACT_RSVD,   VAL_MIN);
    offer(ACT_RSVD,   5);
    offer(ACT_REMOVE, 0);
    offer(ACT_REMOVE, 0);
    offer(ACT_QUERY,  0);
    offer(ACT_REMOVE, VAL_MIN);
    offer(ACT_QUERY,  VAL_MIN);
    offer(ACT_ADD,    VAL_MAX - 1);
    offer(ACT_ADD,    VAL_MIN + 1);
    offer(ACT_REMOVE, VAL_MAX);
    offer(ACT_QUERY,  -1);

    // grow / mixed / shrink phases, so the set fills and drains
    for (seg = 0; seg < 7; seg++) begin
      case (seg % 3)
        0: begin
          add_pct = 75;
          rem_pct = 10;
        end
        1: begin
          add_pct = 40;
          rem_pct = 40;
        end
        default: begin
          add_pct = 15;
          rem_pct = 70;
        end
      endcase
      repeat (200) begin
        r = $urandom_range(0, 99);
        if (r < add_pct) act = ACT_ADD;
        else if (r < add_pct + rem_pct) act = ACT_REMOVE;
        else act = ($urandom_range(0, 4) == 0) ? ACT_RSVD : ACT_QUERY;
        if ($urandom_range(0, 99) < 85) v = pool[$urandom_range(0, POOL_N - 1)];
        else v = $urandom;
        offer(act, v);
      end
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d requests, %0d replies checked: %0d found held, %0d adds dropped as full",
             items_sent, replies, hits, rejects);
    $display("Peak occupancy %0d of %0d entries, %0d mismatches, %0d cycles",
             peak_fill, CAPACITY_DEFAULT, mismatches, cycle_cnt);
    if (mismatches == 0 && pending == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
